@@ sv/lsi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsi_pkg: shared types and constants for the segment intersect unit
// Outcome codes and the default coordinate width.
// ----------------------------------------------------------------------------
package lsi_pkg;

  localparam int unsigned CoordWidthDef = 16;

  typedef enum logic [1:0] {
    OC_NONE     = 2'd0,
    OC_POINT    = 2'd1,
    OC_COINCIDE = 2'd2
  } outcome_e;

endpackage
`default_nettype wire

@@ sv/lsi_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsi_divider: shared unsigned restoring divider
// One quotient bit per cycle; gives quotient and remainder of magnitudes.
// ----------------------------------------------------------------------------
module lsi_divider import lsi_pkg::*; #(
  parameter int unsigned W = 2 * CoordWidthDef + 4
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] num_i,
  input  wire logic [W-1:0] den_i,
  output logic              done_o,
  output logic [W-1:0]      quo_o,
  output logic [W-1:0]      rem_o
);

  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [W:0]      trial;
  logic [W:0]      shifted;

  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q, quo_q[W-1]};
    trial   = shifted - {1'b0, den_q};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

@@ sv/lattice_segment_intersect_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lattice_segment_intersect_unit: lattice crossing of two segments
// Determinant solve, Euclid gcd and exact divides on one shared divider.
// ----------------------------------------------------------------------------
// channel | direction | fields
// in      | input     | first_*, second_* endpoints
// out     | output    | outcome, cross_x, cross_y
//
// A non-parallel request takes 5 to about 53 divider runs of width
// W = 2*CW+4, set by the Euclid step count of the gcd.
// A parallel pair skips the divider.
// Products are formed one multiply per cycle with a register after each.
// The input is not ready while a request is at work or a result waits.
// Reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module lattice_segment_intersect_unit import lsi_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [COORD_WIDTH-1:0] first_ax_i,
  input  wire logic signed [COORD_WIDTH-1:0] first_ay_i,
  input  wire logic signed [COORD_WIDTH-1:0] first_bx_i,
  input  wire logic signed [COORD_WIDTH-1:0] first_by_i,
  input  wire logic signed [COORD_WIDTH-1:0] second_ax_i,
  input  wire logic signed [COORD_WIDTH-1:0] second_ay_i,
  input  wire logic signed [COORD_WIDTH-1:0] second_bx_i,
  input  wire logic signed [COORD_WIDTH-1:0] second_by_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         outcome_o,
  output logic signed [COORD_WIDTH-1:0]      cross_x_o,
  output logic signed [COORD_WIDTH-1:0]      cross_y_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned DW = CW + 1;        // differences
  localparam int unsigned MW = CW + 3;        // second multiplier operand
  localparam int unsigned PW = 2 * CW + 4;    // products, det, tn
  localparam int unsigned Limit = 1 << (CW + 1);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_P0    = 14'b00000000000010,  // m11*m22
    S_P1    = 14'b00000000000100,  // m12*m21 -> det
    S_P2    = 14'b00000000001000,  // r1*m22
    S_P3    = 14'b00000000010000,  // m12*r2 -> tn; or parallel checks
    S_PAR   = 14'b00000000100000,
    S_GCD   = 14'b00000001000000,
    S_RTN   = 14'b00000010000000,  // tn / g
    S_RDET  = 14'b00000100000000,  // det / g
    S_ADVX  = 14'b00001000000000,  // m11 / det
    S_ADVY  = 14'b00010000000000,  // m21 / det
    S_BOUND = 14'b00100000000000,
    S_WAIT  = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q, dx_q, dy_q;
  logic signed [DW-1:0] m11, m12, m21, m22, r1, r2;
  logic signed [PW-1:0] prod_q, prod_d, det_q, det_d, tn_q, tn_d;
  logic signed [PW-1:0] ga_q, ga_d, gb_q, gb_d;     // euclid pair
  logic signed [PW-1:0] kx_q, kx_d, ky_q, ky_d;
  logic [3:0]           pstep_q, pstep_d;
  logic [1:0]           oc_q, oc_d;
  logic                 bad_q, bad_d;
  logic signed [CW-1:0] x_q, x_d, y_q, y_d;
  logic signed [DW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;
  state_e               ret_q, ret_d;

  logic          div_start;
  logic [PW-1:0] div_num, div_den, div_quo, div_rem;
  logic          div_done;

  assign m11 = DW'(bx_q) - DW'(ax_q);
  assign m21 = DW'(by_q) - DW'(ay_q);
  assign m12 = DW'(cx_q) - DW'(dx_q);
  assign m22 = DW'(cy_q) - DW'(dy_q);
  assign r1  = DW'(cx_q) - DW'(ax_q);
  assign r2  = DW'(cy_q) - DW'(ay_q);

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  function automatic logic [PW-1:0] absv(input logic signed [PW-1:0] v);
    absv = v[PW-1] ? PW'(-v) : PW'(v);
  endfunction

  function automatic logic in_span(input logic signed [PW-1:0] v,
                                   input logic signed [CW-1:0] e0,
                                   input logic signed [CW-1:0] e1);
    logic signed [PW-1:0] lo, hi;
    lo = (e0 < e1) ? PW'(e0) : PW'(e1);
    hi = (e0 < e1) ? PW'(e1) : PW'(e0);
    in_span = (lo <= v) && (v <= hi);
  endfunction

  lsi_divider #(.W(PW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // sign-corrected quotient (C truncation semantics)
  logic                 qneg;
  logic signed [PW-1:0] squo;
  logic signed [PW-1:0] pos_x, pos_y;
  logic signed [PW-1:0] tk;
  logic [PW-1:0]        atn;

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    prod_d    = prod_q;
    det_d     = det_q;
    tn_d      = tn_q;
    ga_d      = ga_q;
    gb_d      = gb_q;
    kx_d      = kx_q;
    ky_d      = ky_q;
    pstep_d   = pstep_q;
    oc_d      = oc_q;
    bad_d     = bad_q;
    x_d       = x_q;
    y_d       = y_q;
    mul_a     = m11;
    mul_b     = MW'(m22);
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    qneg      = 1'b0;
    squo      = '0;
    atn       = absv(tn_q);
    pos_x     = '0;
    pos_y     = '0;
    tk        = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_P0;
      end
      S_P0: begin
        mul_a   = m11;
        mul_b   = MW'(m22);
        prod_d  = mul_p;
        state_d = S_P1;
      end
      S_P1: begin
        mul_a   = m12;
        mul_b   = MW'(m21);
        det_d   = prod_q - mul_p;
        state_d = S_P2;
      end
      S_P2: begin
        mul_a   = r1;
        mul_b   = MW'(m22);
        prod_d  = mul_p;
        state_d = S_P3;
      end
      S_P3: begin
        mul_a = m12;
        mul_b = MW'(r2);
        tn_d  = prod_q - mul_p;
        if (det_q == '0) begin
          bad_d   = ((m11 == '0) && (m12 == '0) && (r1 != '0)) ||
                    ((m21 == '0) && (m22 == '0) && (r2 != '0));
          pstep_d = '0;
          state_d = S_PAR;
        end else begin
          ga_d    = PW'(absv(prod_q - mul_p));
          gb_d    = PW'(absv(det_q));
          state_d = S_GCD;
        end
      end
      S_PAR: begin
        // proportionality: m11*r2 == r1*m21 and m12*r2 == r1*m22
        case (pstep_q)
          4'd0: begin mul_a = m11; mul_b = MW'(r2);  prod_d = mul_p; end
          4'd1: begin mul_a = r1;  mul_b = MW'(m21);
            if (prod_q != mul_p) bad_d = 1'b1; end
          4'd2: begin mul_a = m12; mul_b = MW'(r2);  prod_d = mul_p; end
          4'd3: begin mul_a = r1;  mul_b = MW'(m22);
            if (prod_q != mul_p) bad_d = 1'b1; end
          default: ;
        endcase
        pstep_d = pstep_q + 1'b1;
        if (pstep_q == 4'd3) begin
          oc_d    = (bad_d) ? OC_NONE : OC_COINCIDE;
          x_d     = '0;
          y_d     = '0;
          state_d = S_OUT;
        end
      end
      S_GCD: begin
        if (gb_q == '0) begin
          // ga holds gcd
          div_start = 1'b1;
          div_num   = absv(tn_q);
          div_den   = ga_q;
          ret_d     = S_RTN;
          state_d   = S_WAIT;
        end else begin
          div_start = 1'b1;
          div_num   = ga_q;
          div_den   = gb_q;
          ret_d     = S_GCD;
          state_d   = S_WAIT;
        end
      end
      S_WAIT: begin
        if (div_done) begin
          state_d = ret_q;
          if (ret_q == S_GCD) begin
            ga_d = gb_q;
            gb_d = div_rem;
          end else if (ret_q == S_RTN) begin
            tn_d = tn_q[PW-1] ? -$signed(div_quo) : $signed(div_quo);
          end else if (ret_q == S_RDET) begin
            det_d = det_q[PW-1] ? -$signed(div_quo) : $signed(div_quo);
          end else begin
            qneg = ((ret_q == S_ADVX) ? m11[DW-1] : m21[DW-1]) ^ det_q[PW-1];
            squo = qneg ? -$signed(div_quo) : $signed(div_quo);
            if (div_rem != '0) bad_d = 1'b1;
            if (ret_q == S_ADVX) kx_d = squo;
            else ky_d = squo;
          end
        end
      end
      S_RTN: begin
        div_start = 1'b1;
        div_num   = absv(det_q);
        div_den   = ga_q;
        ret_d     = S_RDET;
        state_d   = S_WAIT;
      end
      S_RDET: begin
        bad_d     = 1'b0;
        div_start = 1'b1;
        div_num   = absv(PW'(m11));
        div_den   = absv(det_q);
        ret_d     = S_ADVX;
        state_d   = S_WAIT;
      end
      S_ADVX: begin
        div_start = 1'b1;
        div_num   = absv(PW'(m21));
        div_den   = absv(det_q);
        ret_d     = S_ADVY;
        state_d   = S_WAIT;
      end
      S_ADVY: begin
        pstep_d = '0;
        state_d = S_BOUND;
      end
      S_BOUND: begin
        // |tn| > Limit/|k| holds exactly when |tn|*|k| > Limit; |k| < 2^CW,
        // so |tn| > Limit alone already fails and the product stays narrow
        case (pstep_q)
          4'd0: begin
            mul_a = DW'(absv(kx_q));
            mul_b = MW'(atn);
            if (kx_q != '0 && (atn > PW'(Limit) || mul_p > PW'(Limit))) bad_d = 1'b1;
          end
          4'd1: begin
            mul_a  = DW'(kx_q);
            mul_b  = MW'(tn_q);
            prod_d = mul_p;
          end
          4'd2: begin
            mul_a = DW'(absv(ky_q));
            mul_b = MW'(atn);
            if (ky_q != '0 && (atn > PW'(Limit) || mul_p > PW'(Limit))) bad_d = 1'b1;
          end
          4'd3: begin
            mul_a = DW'(ky_q);
            mul_b = MW'(tn_q);
            pos_x = PW'(ax_q) + prod_q;
            tk    = mul_p;
            pos_y = PW'(ay_q) + tk;
            if (bad_d || !in_span(pos_x, ax_q, bx_q) || !in_span(pos_y, ay_q, by_q) ||
                !in_span(pos_x, cx_q, dx_q) || !in_span(pos_y, cy_q, dy_q)) begin
              oc_d = OC_NONE;
              x_d  = '0;
              y_d  = '0;
            end else begin
              oc_d = OC_POINT;
              x_d  = pos_x[CW-1:0];
              y_d  = pos_y[CW-1:0];
            end
            state_d = S_OUT;
          end
          default: ;
        endcase
        pstep_d = pstep_q + 1'b1;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      pstep_q <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      pstep_q <= pstep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      ax_q <= first_ax_i;
      ay_q <= first_ay_i;
      bx_q <= first_bx_i;
      by_q <= first_by_i;
      cx_q <= second_ax_i;
      cy_q <= second_ay_i;
      dx_q <= second_bx_i;
      dy_q <= second_by_i;
    end
    prod_q <= prod_d;
    det_q  <= det_d;
    tn_q   <= tn_d;
    ga_q   <= ga_d;
    gb_q   <= gb_d;
    kx_q   <= kx_d;
    ky_q   <= ky_d;
    oc_q   <= oc_d;
    bad_q  <= bad_d;
    x_q    <= x_d;
    y_q    <= y_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign outcome_o   = oc_q;
  assign cross_x_o   = x_q;
  assign cross_y_o   = y_q;

endmodule
`default_nettype wire

@@ tb/sv/lattice_segment_intersect_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_segment_intersect_unit_tb: lattice crossing of two segments
// Drives segment pairs with bursty valid, stalls the result side on its own
// pattern and checks outcome and point against an in-bench exact solver.
// ----------------------------------------------------------------------------
module lattice_segment_intersect_unit_tb;
  import lsi_pkg::*;

  localparam int CW = CoordWidthDef;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct packed {
    outcome_e oc;
    coord_t   x;
    coord_t   y;
  } crossing_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  coord_t first_ax_i = '0, first_ay_i = '0, first_bx_i = '0, first_by_i = '0;
  coord_t second_ax_i = '0, second_ay_i = '0, second_bx_i = '0, second_by_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] outcome_o;
  coord_t cross_x_o, cross_y_o;

  crossing_t pending_crossings[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stall_on = 1'b0;
  int stall_mode = 0;
  int burst_left = 0;

  always #5 clk_i = ~clk_i;

  lattice_segment_intersect_unit dut (.*);

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit in_span(longint v, longint e0, longint e1);
    return (v >= (e0 < e1 ? e0 : e1)) && (v <= (e0 < e1 ? e1 : e0));
  endfunction

  // base + tn*delta/td, only if delta divides exactly and offset stays near box
  function automatic bit step_along(longint base, longint tn, longint td, longint delta,
                                    output longint res);
    longint k;
    longint lim;
    lim = longint'(1) << (CW + 1);
    res = 0;
    if (delta % td != 0) return 1'b0;
    k = delta / td;
    if (k != 0 && mag(tn) > lim / mag(k)) return 1'b0;
    res = base + tn * k;
    return 1'b1;
  endfunction

  function automatic crossing_t solve_crossing(longint ax, longint ay, longint bx,
                                               longint by, longint cx, longint cy,
                                               longint dx, longint dy);
    crossing_t r;
    longint m11, m12, r1, m21, m22, r2, det, tn, u, w, t, x, y;
    r = '{OC_NONE, '0, '0};
    m11 = bx - ax; m12 = cx - dx; r1 = cx - ax;
    m21 = by - ay; m22 = cy - dy; r2 = cy - ay;
    det = m11 * m22 - m12 * m21;
    if (det == 0) begin
      if (m11 == 0 && m12 == 0 && r1 != 0) return r;
      if (m21 == 0 && m22 == 0 && r2 != 0) return r;
      if (m11 * r2 != r1 * m21 || m12 * r2 != r1 * m22) return r;
      r.oc = OC_COINCIDE;
      return r;
    end
    tn = r1 * m22 - m12 * r2;
    u = mag(tn); w = mag(det);
    while (w != 0) begin
      t = u % w; u = w; w = t;
    end
    tn /= u; det /= u;
    if (!step_along(ax, tn, det, m11, x)) return r;
    if (!step_along(ay, tn, det, m21, y)) return r;
    if (!in_span(x, ax, bx) || !in_span(y, ay, by)) return r;
    if (!in_span(x, cx, dx) || !in_span(y, cy, dy)) return r;
    r.oc = OC_POINT; r.x = coord_t'(x); r.y = coord_t'(y);
    return r;
  endfunction

  // Sender gaps: bursts of random length with random gaps between them.
  task automatic sender_gap();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 6);
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_segments(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                               coord_t cx, coord_t cy, coord_t dx, coord_t dy);
    sender_gap();
    first_ax_i <= ax; first_ay_i <= ay; first_bx_i <= bx; first_by_i <= by;
    second_ax_i <= cx; second_ay_i <= cy; second_bx_i <= dx; second_by_i <= dy;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_crossings.push_back(solve_crossing(ax, ay, bx, by, cx, cy, dx, dy));
  endtask

  function automatic coord_t rnd_coord(int span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_crossings.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_extremes();
    coord_t mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    send_segments(mn, mn, mx, mx, mn, mx, mx, mn);
    send_segments(mx, mx, mn, mn, mx, mn, mn, mx);
    send_segments(mn, mn, mx, mn, mn, mx, mx, mx);
    send_segments(mn, 0, mx, 0, 0, mn, 0, mx);
    send_segments(mn, mn, mn, mn, mx, mx, mx, mx);
    send_segments(-1, -1, -1, -1, -1, -1, -1, -1);
  endtask

  task automatic test_special_cases();
    send_segments(0, 0, 4, 4, 0, 4, 4, 0);     // lattice point
    send_segments(0, 0, 1, 1, 0, 1, 1, 0);     // crossing at half
    send_segments(0, 0, 2, 2, 5, 0, 7, 2);     // parallel apart
    send_segments(0, 0, 2, 2, 5, 5, 9, 9);     // collinear disjoint
    send_segments(3, 3, 3, 3, 3, 3, 3, 3);     // all points equal
    send_segments(3, 3, 3, 3, 7, 7, 7, 7);     // two distinct points
    send_segments(0, 0, 2, 2, 0, 10, 10, 0);   // crossing beyond first box
    send_segments(0, 0, 1, 0, 500, 1, 500, -1); // far outside
    send_segments(-5, 0, 5, 0, 0, -5, 0, 5);   // axis cross at origin
    send_segments(0, 0, 10, 0, 10, 0, 10, 5);  // touching endpoint
    send_segments(0, 0, 0, 0, 0, 0, 4, 4);     // zero length on line
    send_segments(0, 0, 3, 1, 1, 2, 4, 3);     // non-integral parallel shift
    wait_drained();
  endtask

  task automatic test_random();
    coord_t p[8];
    int span;
    int gx, gy;
    for (int n = 0; n < 500; n++) begin
      case ($urandom_range(0, 3))
        0: span = 0;
        1: span = 20;
        2: span = 1000;
        default: span = 8;
      endcase
      foreach (p[i]) p[i] = rnd_coord(span);
      // often build segments through a shared lattice point
      if ($urandom_range(0, 2) == 0) begin
        gx = $urandom_range(0, 200) - 100; gy = $urandom_range(0, 200) - 100;
        p[2] = coord_t'(2 * gx - p[0]); p[3] = coord_t'(2 * gy - p[1]);
        p[6] = coord_t'(2 * gx - p[4]); p[7] = coord_t'(2 * gy - p[5]);
      end else if ($urandom_range(0, 5) == 0) begin
        p[4] = coord_t'(p[0] + (p[2] - p[0]) * 2);
        p[5] = coord_t'(p[1] + (p[3] - p[1]) * 2);
      end
      send_segments(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
      if (n == 250) wait_drained();
    end
  endtask

  // Result side: stall patterns change every so often, with some stall-free runs.
  always @(posedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= $urandom_range(0, 1);
      2: out_ready_i <= ($urandom_range(0, 7) == 0);
      default: out_ready_i <= ~out_ready_i;
    endcase
  end

  always @(posedge clk_i) begin
    crossing_t exp_c;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_crossings.size() == 0) begin
        $display("%0t result with none expected: got %0d %0d %0d", $time,
                 outcome_o, cross_x_o, cross_y_o);
        errors++;
      end else begin
        exp_c = pending_crossings.pop_front();
        if (outcome_o !== exp_c.oc || cross_x_o !== exp_c.x || cross_y_o !== exp_c.y) begin
          $display("%0t mismatch: expected %0d %0d %0d actual %0d %0d %0d", $time,
                   exp_c.oc, exp_c.x, exp_c.y, outcome_o, cross_x_o, cross_y_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_special_cases();
    test_random();
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending_crossings.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
